@@ rtl/core/mslt_pkg.sv @@
// ----------------------------------------------------------------------------
// MAC side learning table package
// Shared sizes, codes and types of the learning table core.
// ----------------------------------------------------------------------------
package mslt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int TIME_WIDTH  = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam int OPCODE_W = 2;
  localparam int MAC_W    = 48;
  localparam int TS_W     = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 32;
  localparam int ENTRY_W  = TIME_WIDTH + COUNT_W;

  localparam int OP_SIDE_BIT  = 0;
  localparam int OP_QUERY_BIT = 1;

  localparam logic [MAC_W-1:0]   MAC_BCAST = {MAC_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

  localparam logic [STATUS_W-1:0] ST_BCAST  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HIT    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INSERT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MOVED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_MISS   = 3'd5;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [MAC_W-1:0]    mac;
    logic [TS_W-1:0]     timestamp;
  } in_item_t;

  typedef struct packed {
    logic                known;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  hit_count;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

  typedef enum logic {
    CS_IDLE,
    CS_UPDATE
  } ctrl_state_t;

endpackage

@@ rtl/core/mslt_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with a registered read.
// ----------------------------------------------------------------------------
module mslt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/mslt_ctrl.sv @@
// ----------------------------------------------------------------------------
// MAC side learning table controller
// Sequences the capture and update steps and drives the result strobe.
// ----------------------------------------------------------------------------
module mslt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output logic                out_valid,
  output mslt_pkg::ctrl_cmd_t cmd
);

  mslt_pkg::ctrl_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mslt_pkg::CS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    busy          = 1'b0;
    case (state_r)
      mslt_pkg::CS_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = mslt_pkg::CS_UPDATE;
        end
      end
      mslt_pkg::CS_UPDATE: begin
        busy          = 1'b1;
        cmd.commit    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = mslt_pkg::CS_IDLE;
      end
      default: begin
        state_nxt = mslt_pkg::CS_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/core/mslt_datapath.sv @@
// ----------------------------------------------------------------------------
// MAC side learning table datapath
// Address match array, free slot search, count store and result register.
// ----------------------------------------------------------------------------
module mslt_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  mslt_pkg::ctrl_cmd_t cmd,
  input  mslt_pkg::in_item_t  in_item,
  output mslt_pkg::out_item_t out_item
);

  logic [mslt_pkg::TABLE_DEPTH-1:0] valid_r;
  logic [mslt_pkg::TABLE_DEPTH-1:0] remote_r;
  logic [mslt_pkg::MAC_W-1:0]       addr_r [mslt_pkg::TABLE_DEPTH];

  logic [mslt_pkg::TABLE_DEPTH-1:0] match;
  logic [mslt_pkg::TABLE_DEPTH-1:0] same;
  logic [mslt_pkg::TABLE_DEPTH-1:0] free_onehot;
  logic [mslt_pkg::IDX_W-1:0]       hit_idx;
  logic [mslt_pkg::IDX_W-1:0]       free_idx;

  logic [mslt_pkg::OPCODE_W-1:0] op_r;
  logic [mslt_pkg::MAC_W-1:0]    mac_r;
  logic [mslt_pkg::TS_W-1:0]     ts_r;
  logic                          hit_any_r;
  logic                          hit_same_r;
  logic                          full_r;
  logic [mslt_pkg::IDX_W-1:0]    hit_idx_r;
  logic [mslt_pkg::IDX_W-1:0]    free_idx_r;

  logic [mslt_pkg::ENTRY_W-1:0]  ram_rdata;
  logic [mslt_pkg::ENTRY_W-1:0]  ram_wdata;
  logic                          ram_we;
  logic [mslt_pkg::IDX_W-1:0]    wr_idx;
  logic [mslt_pkg::COUNT_W-1:0]  cnt_old;
  logic [mslt_pkg::COUNT_W-1:0]  cnt_inc;
  logic [mslt_pkg::COUNT_W-1:0]  wr_count;
  logic                          do_write;
  logic                          do_move;
  logic                          do_insert;
  mslt_pkg::out_item_t           res;
  mslt_pkg::out_item_t           out_item_r;

  always_comb begin
    for (int i = 0; i < mslt_pkg::TABLE_DEPTH; i++) begin
      match[i] = valid_r[i] && (addr_r[i] == in_item.mac);
      same[i]  = match[i] && (remote_r[i] == in_item.opcode[mslt_pkg::OP_SIDE_BIT]);
    end
  end

  // An address sits in at most one slot, so the match vector is one-hot or empty.
  assign free_onehot = ~valid_r & (valid_r + mslt_pkg::TABLE_DEPTH'(1));

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < mslt_pkg::TABLE_DEPTH; i++) begin
      if (match[i]) begin
        hit_idx = hit_idx | mslt_pkg::IDX_W'(i);
      end
      if (free_onehot[i]) begin
        free_idx = free_idx | mslt_pkg::IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= in_item.opcode;
      mac_r      <= in_item.mac;
      ts_r       <= in_item.timestamp;
      hit_any_r  <= |match;
      hit_same_r <= |same;
      full_r     <= &valid_r;
      hit_idx_r  <= hit_idx;
      free_idx_r <= free_idx;
    end
  end

  assign cnt_old = ram_rdata[mslt_pkg::COUNT_W-1:0];
  assign cnt_inc = (cnt_old == mslt_pkg::COUNT_MAX) ? cnt_old
                                                   : cnt_old + mslt_pkg::COUNT_ONE;

  always_comb begin
    do_write      = 1'b0;
    do_move       = 1'b0;
    do_insert     = 1'b0;
    wr_idx        = hit_idx_r;
    wr_count      = mslt_pkg::COUNT_ONE;
    res.known     = 1'b0;
    res.status    = mslt_pkg::ST_BCAST;
    res.hit_count = '0;
    if (mac_r == mslt_pkg::MAC_BCAST) begin
      res.status = mslt_pkg::ST_BCAST;
    end else if (hit_same_r) begin
      do_write      = 1'b1;
      wr_count      = cnt_inc;
      res.known     = 1'b1;
      res.status    = mslt_pkg::ST_HIT;
      res.hit_count = cnt_inc;
    end else if (op_r[mslt_pkg::OP_QUERY_BIT]) begin
      res.status = mslt_pkg::ST_MISS;
    end else if (hit_any_r) begin
      do_write      = 1'b1;
      do_move       = 1'b1;
      res.status    = mslt_pkg::ST_MOVED;
      res.hit_count = mslt_pkg::COUNT_ONE;
    end else if (!full_r) begin
      do_write      = 1'b1;
      do_insert     = 1'b1;
      wr_idx        = free_idx_r;
      res.status    = mslt_pkg::ST_INSERT;
      res.hit_count = mslt_pkg::COUNT_ONE;
    end else begin
      res.status = mslt_pkg::ST_FULL;
    end
  end

  assign ram_we    = cmd.commit && do_write;
  assign ram_wdata = {mslt_pkg::TIME_WIDTH'(ts_r), wr_count};

  mslt_ram #(
    .WIDTH (mslt_pkg::ENTRY_W),
    .DEPTH (mslt_pkg::TABLE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx),
    .wdata (ram_wdata),
    .re    (cmd.capture),
    .raddr (hit_idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.commit && do_insert) begin
      valid_r[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && (do_insert || do_move)) begin
      remote_r[wr_idx] <= op_r[mslt_pkg::OP_SIDE_BIT];
    end
    if (cmd.commit && do_insert) begin
      addr_r[wr_idx] <= mac_r;
    end
    if (cmd.commit) begin
      out_item_r <= res;
    end
  end

  assign out_item = out_item_r;

endmodule

@@ rtl/core/mac_side_learning_table_core.sv @@
// ----------------------------------------------------------------------------
// MAC side learning table core
// Learns and looks up 48-bit addresses on a local or a remote side.
// ----------------------------------------------------------------------------
// An item is taken on in_item at a rising edge where start is high and busy
// is low. Opcodes learn or query an address on the local or remote side; the
// item also carries the time to store as last seen.
// Each item gives exactly one result on out_item. It is shown for a single
// cycle with out_valid high, from the first edge after the accepting edge,
// and is taken at the edge that ends that cycle.
// In the cycle that ends at the accepting edge the table is compared in
// parallel, and the matching slot's count is read from the entry RAM at that
// edge. In the next cycle the count is updated and written back. Busy is high
// during that update cycle only, so a new item cannot be accepted until the
// update is done, a limit set by the registered read of the entry RAM ahead
// of the count update.
// The receiver has no way to stall; a result must be taken as it appears.
// Synchronous reset marks every slot free and drops any item in flight; no
// clearing pass is needed, so items are accepted straight after reset.
// ----------------------------------------------------------------------------
module mac_side_learning_table_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mslt_pkg::in_item_t  in_item,
  output logic                out_valid,
  output mslt_pkg::out_item_t out_item
);

  mslt_pkg::ctrl_cmd_t cmd;

  mslt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  mslt_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

  a_result_follows_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(cmd.commit))
    else $error("Result strobe without a preceding update cycle.");

  a_accept_starts_update: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && cmd.commit))
    else $error("Accepted item did not enter the update cycle.");

  a_update_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (!busy && out_valid))
    else $error("Update cycle did not end with a result.");

  a_known_only_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.known) |-> (out_item.status == mslt_pkg::ST_HIT))
    else $error("Address reported known without a hit.");

  a_no_count_without_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status == mslt_pkg::ST_BCAST ||
                   out_item.status == mslt_pkg::ST_FULL ||
                   out_item.status == mslt_pkg::ST_MISS))
    |-> (out_item.hit_count == '0 && !out_item.known))
    else $error("Count reported for an item with no entry.");

endmodule
